[hdl/dcp_pkg.sv]
package dcp_pkg;

	localparam int MAX_DEVICES_DEF = 16;
	localparam int DATA_BYTES_DEF  = 6;

	localparam int BYTE_W = 8;
	localparam int DATA_W = 48;
	localparam int DEV_W  = 4;
	localparam int CFG_W  = 5;
	localparam int CRC_W  = 16;

	localparam logic [CRC_W-1:0] CRC_SEED = 16'd16;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h4599;
	localparam logic [CFG_W-1:0] DEV_COUNT_RESET = 5'd1;

	// byte-wise crc15 table entry
	function automatic logic [CRC_W-1:0] crc_table_entry(input logic [BYTE_W-1:0] idx);
		logic [CRC_W-1:0] r;
		r = {1'b0, idx, 7'd0};
		for (int b = 0; b < 8; b++) begin
			if (r[14])
				r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			else
				r = {r[CRC_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hdl/dcp_if.sv]
interface dcp_in_if;
	logic                         valid;
	logic                         ready;
	logic [dcp_pkg::BYTE_W-1:0]   rx_byte;
	logic                         frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface dcp_out_if;
	logic                         valid;
	logic                         ready;
	logic [dcp_pkg::DEV_W-1:0]    device_index;
	logic [dcp_pkg::DATA_W-1:0]   group_data;
	logic                         pec_ok;
	logic                         frame_last;
	logic                         frame_error;

	modport source (output valid, output device_index, output group_data, output pec_ok,
		output frame_last, output frame_error, input ready);
	modport sink   (input valid, input device_index, input group_data, input pec_ok,
		input frame_last, input frame_error, output ready);
endinterface

interface dcp_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [dcp_pkg::CFG_W-1:0]    device_count;

	modport source (output valid, output device_count, input ready);
	modport sink   (input valid, input device_count, output ready);
endinterface

[hdl/daisy_chain_pec15_checker.sv]
// channel | dir | payload                                                 | beat
// rx      | in  | rx_byte, frame_start                                    | one reply byte
// res     | out | device_index, group_data, pec_ok, frame_last, frame_error | one group result
// cfg     | in  | device_count                                            | register write
//
// one byte per cycle unless a held result stalls the input stage; a byte enters the
// input stage, and from there the crc update and group check run into the result register
// the crc table lookup plus xor sets the rate
// arst_n clears all control state; device_count resets to 1, crc to its seed
// a held result stalls the input stage only when a group end is waiting behind it
module daisy_chain_pec15_checker #(
	parameter int MAX_DEVICES = dcp_pkg::MAX_DEVICES_DEF,
	parameter int DATA_BYTES  = dcp_pkg::DATA_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	dcp_in_if.sink          rx,
	dcp_out_if.source       res,
	dcp_cfg_if.sink         cfg
);

	localparam int POS_W = $clog2(DATA_BYTES + 2);
	localparam int LIM   = (MAX_DEVICES < 16) ? MAX_DEVICES : 16;
	localparam logic [POS_W-1:0]          POS_PEC_HI = POS_W'(DATA_BYTES);
	localparam logic [dcp_pkg::CFG_W-1:0] COUNT_LIM  = dcp_pkg::CFG_W'(LIM);

	logic [dcp_pkg::CFG_W-1:0]  dev_count_q;

	logic                        valid_s1;
	logic [dcp_pkg::BYTE_W-1:0]  byte_s1;
	logic                        start_s1;

	logic [POS_W-1:0]            pos_q;
	logic [dcp_pkg::CRC_W-1:0]   crc_q;
	logic [dcp_pkg::DEV_W-1:0]   dev_q;
	logic [dcp_pkg::DATA_W-1:0]  data_q;
	logic [dcp_pkg::BYTE_W-1:0]  pec_hi_q;
	logic                        sticky_q;

	logic                        res_valid_q;
	logic [dcp_pkg::DEV_W-1:0]   res_dev_q;
	logic [dcp_pkg::DATA_W-1:0]  res_data_q;
	logic                        res_ok_q;
	logic                        res_last_q;
	logic                        res_err_q;

	logic [POS_W-1:0]            pos_e;
	logic [dcp_pkg::CRC_W-1:0]   crc_e;
	logic [dcp_pkg::DEV_W-1:0]   dev_e;
	logic [dcp_pkg::DATA_W-1:0]  data_e;
	logic                        sticky_e;
	logic                        is_data;
	logic                        is_end;
	logic [dcp_pkg::CRC_W-1:0]   crc_next;
	logic [dcp_pkg::DATA_W-1:0]  data_next;
	logic [dcp_pkg::CRC_W-1:0]   computed;
	logic                        ok;
	logic                        err;
	logic                        last;
	logic [dcp_pkg::CFG_W-1:0]   eff_count;
	logic                        stall;
	logic                        take_s1;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_count_q <= dcp_pkg::DEV_COUNT_RESET;
		end else if (cfg.valid) begin
			dev_count_q <= cfg.device_count;
		end
	end

	// frame start restarts the group before the byte is taken
	always_comb begin
		pos_e    = start_s1 ? '0 : pos_q;
		crc_e    = start_s1 ? dcp_pkg::CRC_SEED : crc_q;
		dev_e    = start_s1 ? '0 : dev_q;
		data_e   = start_s1 ? '0 : data_q;
		sticky_e = start_s1 ? 1'b0 : sticky_q;

		is_data = pos_e < POS_PEC_HI;
		is_end  = !is_data && (pos_e != POS_PEC_HI);

		crc_next = {crc_e[7:0], 8'd0}
			^ dcp_pkg::crc_table_entry(crc_e[14:7] ^ byte_s1);

		data_next = data_e;
		for (int i = 0; i < 6; i++) begin
			if (i < DATA_BYTES) begin
				if (pos_e == POS_W'(i))
					data_next[8*i +: 8] = byte_s1;
			end
		end

		computed = {crc_e[dcp_pkg::CRC_W-2:0], 1'b0};
		ok       = computed == {pec_hi_q, byte_s1};
		err      = sticky_e | !ok;

		eff_count = dev_count_q;
		if (eff_count == '0)
			eff_count = dcp_pkg::CFG_W'(1);
		if (eff_count > COUNT_LIM)
			eff_count = COUNT_LIM;
		last = ({1'b0, dev_e} + dcp_pkg::CFG_W'(1)) >= eff_count;
	end

	assign stall   = valid_s1 && is_end && res_valid_q && !res.ready;
	assign take_s1 = valid_s1 && !stall;
	assign rx.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= dcp_pkg::CRC_SEED;
			dev_q    <= '0;
			data_q   <= '0;
			pec_hi_q <= '0;
			sticky_q <= 1'b0;
		end else if (take_s1) begin
			if (is_data) begin
				pos_q    <= pos_e + POS_W'(1);
				crc_q    <= crc_next;
				dev_q    <= dev_e;
				data_q   <= data_next;
				sticky_q <= sticky_e;
				if (start_s1)
					pec_hi_q <= '0;
			end else if (!is_end) begin
				pos_q    <= pos_e + POS_W'(1);
				crc_q    <= crc_e;
				dev_q    <= dev_e;
				data_q   <= data_e;
				pec_hi_q <= byte_s1;
				sticky_q <= sticky_e;
			end else begin
				pos_q    <= '0;
				crc_q    <= dcp_pkg::CRC_SEED;
				data_q   <= '0;
				pec_hi_q <= '0;
				dev_q    <= last ? '0 : dev_e + dcp_pkg::DEV_W'(1);
				sticky_q <= last ? 1'b0 : err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_s1 && is_end) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && is_end) begin
			res_dev_q  <= dev_e;
			res_data_q <= data_e;
			res_ok_q   <= ok;
			res_last_q <= last;
			res_err_q  <= err;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.device_index = res_dev_q;
	assign res.group_data   = res_data_q;
	assign res.pec_ok       = res_ok_q;
	assign res.frame_last   = res_last_q;
	assign res.frame_error  = res_err_q;

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(DATA_BYTES + 1))
		else $error("byte position out of range");

	a_failed_sets_error: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.pec_ok |-> res.frame_error)
		else $error("failed group without frame error");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && is_end && last |=> dev_q == '0 && !sticky_q && pos_q == '0)
		else $error("frame end did not clear device state");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> valid_s1 && res_valid_q && !res.ready)
		else $error("input stalled without a held result");
`endif

endmodule

[sim/daisy_chain_pec15_checker_tb.sv]
`timescale 1ns / 1ps

module daisy_chain_pec15_checker_tb;

	typedef struct packed {
		logic [dcp_pkg::DEV_W-1:0]  device_index;
		logic [dcp_pkg::DATA_W-1:0] group_data;
		logic                       pec_ok;
		logic                       frame_last;
		logic                       frame_error;
	} grp_result_t;

	typedef enum logic [1:0] {ROW_LIT, ROW_PEC_HI, ROW_PEC_LO} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [dcp_pkg::BYTE_W-1:0] rx_byte;
		logic                       frame_start;
		logic                       typed;
		grp_result_t                want;
	} dir_row_t;

	localparam grp_result_t NO_RESULT = '0;
	localparam grp_result_t ZERO_GROUP_BAD = '{4'd0, 48'd0, 1'b0, 1'b1, 1'b1};
	localparam grp_result_t ONES_GROUP_BAD = '{4'd0, 48'hffff_ffff_ffff, 1'b0, 1'b1, 1'b1};
	localparam int DIR_ROW_COUNT = 26;

	// zero group with an odd pec, a cut group, all-ones group with an odd pec, a good group
	localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
		'{ROW_LIT,    8'h00, 1'b1, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h01, 1'b0, 1'b1, ZERO_GROUP_BAD},
		'{ROW_LIT,    8'h5a, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'ha5, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b1, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hff, 1'b0, 1'b1, ONES_GROUP_BAD},
		'{ROW_LIT,    8'h01, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h80, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h55, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'haa, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'h7f, 1'b0, 1'b0, NO_RESULT},
		'{ROW_LIT,    8'hfe, 1'b0, 1'b0, NO_RESULT},
		'{ROW_PEC_HI, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{ROW_PEC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT}
	};

	localparam int PHASES = 10;
	localparam int PHASE_BYTES = 190;
	localparam logic [dcp_pkg::CFG_W-1:0] COUNT_PLAN [PHASES] = '{
		5'd0, 5'd16, 5'd31, 5'd3, 5'd1, 5'd7, 5'd17, 5'd2, 5'd12, 5'd5
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dcp_in_if  rx_if ();
	dcp_out_if res_if ();
	dcp_cfg_if cfg_if ();

	daisy_chain_pec15_checker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// predictor state
	int                         grp_pos;
	logic [dcp_pkg::CRC_W-1:0]  pec_rem;
	logic [dcp_pkg::DEV_W-1:0]  dev_ctr;
	logic [dcp_pkg::DATA_W-1:0] data_acc;
	logic [dcp_pkg::BYTE_W-1:0] pec_hi;
	logic                       frame_err;
	logic [dcp_pkg::CFG_W-1:0]  dev_count_reg;

	grp_result_t expected_groups [$];
	logic        step_had_result;
	grp_result_t step_result;

	int errors = 0;
	int groups_seen = 0;
	int bad_pec_groups = 0;
	int bytes_sent = 0;
	int settings_done = 0;
	int phase_left = 0;
	bit calm_tx = 1'b0;
	bit calm_rx = 1'b0;

	function automatic logic [dcp_pkg::CRC_W-1:0] pec15_after_byte(
		input logic [dcp_pkg::CRC_W-1:0] rem, input logic [dcp_pkg::BYTE_W-1:0] b);
		logic [dcp_pkg::CRC_W-1:0] t;
		t = {1'b0, rem[14:7] ^ b, 7'd0};
		repeat (8) begin
			if (t[14])
				t = {t[dcp_pkg::CRC_W-2:0], 1'b0} ^ dcp_pkg::CRC_POLY;
			else
				t = {t[dcp_pkg::CRC_W-2:0], 1'b0};
		end
		return {rem[7:0], 8'h00} ^ t;
	endfunction

	function automatic int devices_in_frame(input logic [dcp_pkg::CFG_W-1:0] c);
		int lim;
		int n;
		lim = (dcp_pkg::MAX_DEVICES_DEF < 16) ? dcp_pkg::MAX_DEVICES_DEF : 16;
		n = int'(c);
		if (n == 0)
			n = 1;
		if (n > lim)
			n = lim;
		return n;
	endfunction

	function automatic void group_clear();
		grp_pos = 0;
		pec_rem = dcp_pkg::CRC_SEED;
		data_acc = '0;
		pec_hi = '0;
	endfunction

	task automatic pec_track(input logic [dcp_pkg::BYTE_W-1:0] b, input logic fs);
		logic [dcp_pkg::CRC_W-1:0] computed;
		logic                      ok;
		logic                      err;
		logic                      last;
		step_had_result = 1'b0;
		if (fs) begin
			group_clear();
			dev_ctr = '0;
			frame_err = 1'b0;
		end
		if (grp_pos < dcp_pkg::DATA_BYTES_DEF) begin
			pec_rem = pec15_after_byte(pec_rem, b);
			if (grp_pos < 6)
				data_acc[8*grp_pos +: 8] = b;
			grp_pos++;
		end else if (grp_pos == dcp_pkg::DATA_BYTES_DEF) begin
			pec_hi = b;
			grp_pos++;
		end else begin
			computed = {pec_rem[dcp_pkg::CRC_W-2:0], 1'b0};
			ok = (computed == {pec_hi, b});
			err = frame_err | ~ok;
			last = (int'(dev_ctr) + 1) >= devices_in_frame(dev_count_reg);
			step_result = '{dev_ctr, data_acc, ok, last, err};
			step_had_result = 1'b1;
			group_clear();
			if (last) begin
				dev_ctr = '0;
				frame_err = 1'b0;
			end else begin
				dev_ctr = dev_ctr + 1'b1;
				frame_err = err;
			end
		end
	endtask

	function automatic void note_failure(input string what);
		if (errors < 10)
			$display("[%0t] %s", $realtime, what);
		errors++;
	endfunction

	task automatic send_byte(input logic [dcp_pkg::BYTE_W-1:0] b, input logic fs,
		input logic typed, input grp_result_t want);
		int gap;
		if ($urandom_range(0, 31) == 0)
			calm_tx = !calm_tx;
		gap = calm_tx ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		rx_if.frame_start <= fs;
		do @(posedge clk); while (!rx_if.ready);
		bytes_sent++;
		phase_left--;
		pec_track(b, fs);
		if (step_had_result)
			expected_groups.push_back(typed ? want : step_result);
	endtask

	task automatic send_plain(input logic [dcp_pkg::BYTE_W-1:0] b, input logic fs);
		send_byte(b, fs, 1'b0, NO_RESULT);
	endtask

	task automatic set_device_count(input logic [dcp_pkg::CFG_W-1:0] v);
		while (expected_groups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.device_count <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		dev_count_reg = v;
		settings_done++;
	endtask

	task automatic send_group(input logic fs);
		logic [dcp_pkg::BYTE_W-1:0] d;
		logic [dcp_pkg::CRC_W-1:0]  pec;
		int                         mode;
		mode = $urandom_range(0, 15);
		for (int i = 0; i < dcp_pkg::DATA_BYTES_DEF; i++) begin
			d = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hff : 8'($urandom);
			send_plain(d, fs && i == 0);
		end
		pec = {pec_rem[dcp_pkg::CRC_W-2:0], 1'b0};
		if ($urandom_range(0, 7) == 0)
			pec ^= 16'(1) << $urandom_range(0, 15);
		send_plain(pec[15:8], 1'b0);
		send_plain(pec[7:0], 1'b0);
	endtask

	// whole frame; without frame_start only when aligned, so a count change mid-frame shows up
	task automatic send_frame();
		logic fs;
		fs = (grp_pos != 0) || ($urandom_range(0, 3) != 0);
		do begin
			send_group(fs);
			fs = 1'b0;
		end while (!step_result.frame_last && phase_left > 0);
	endtask

	task automatic send_noise(input int n, input int fs_odds);
		for (int i = 0; i < n; i++)
			send_plain(8'($urandom), $urandom_range(0, fs_odds) == 0);
	endtask

	initial begin : stim
		logic [dcp_pkg::BYTE_W-1:0] b;
		int                         pick;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= '0;
		rx_if.frame_start <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.device_count <= '0;
		group_clear();
		dev_ctr = '0;
		frame_err = 1'b0;
		dev_count_reg = dcp_pkg::DEV_COUNT_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROW_COUNT; i++) begin
			case (DIR_ROWS[i].kind)
				ROW_PEC_HI: b = pec_rem[14:7];
				ROW_PEC_LO: b = {pec_rem[6:0], 1'b0};
				default:    b = DIR_ROWS[i].rx_byte;
			endcase
			send_byte(b, DIR_ROWS[i].frame_start, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end
		rx_if.valid <= 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			set_device_count((p == PHASES - 1) ? 5'($urandom) : COUNT_PLAN[p]);
			phase_left = PHASE_BYTES;
			while (phase_left > 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_frame();
				else if (pick == 7)
					send_noise($urandom_range(1, 7), 1);
				else
					send_noise($urandom_range(1, 20), 3);
			end
			rx_if.valid <= 1'b0;
		end

		while (expected_groups.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("checked %0d group results, %0d of them with a bad pec, from %0d reply bytes",
			groups_seen, bad_pec_groups, bytes_sent);
		$display("%0d device_count writes, including 0, 1, 16 and counts above 16",
			settings_done);
		if (errors == 0 && expected_groups.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// result sink with random stalls between beats
	initial begin : result_sink
		int stall;
		res_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm_rx = !calm_rx;
			stall = calm_rx ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	always @(posedge clk) begin : result_check
		grp_result_t got;
		grp_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = '{res_if.device_index, res_if.group_data, res_if.pec_ok,
				res_if.frame_last, res_if.frame_error};
			groups_seen++;
			if (!got.pec_ok)
				bad_pec_groups++;
			if (expected_groups.size() == 0) begin
				note_failure($sformatf("unexpected result beat dev %0d data %h",
					got.device_index, got.group_data));
			end else begin
				want = expected_groups.pop_front();
				if (got.device_index !== want.device_index ||
					got.group_data !== want.group_data ||
					got.pec_ok !== want.pec_ok ||
					got.frame_last !== want.frame_last ||
					got.frame_error !== want.frame_error) begin
					note_failure({
						$sformatf("mismatch exp dev %0d data %h ok %b last %b err %b, ",
							want.device_index, want.group_data, want.pec_ok,
							want.frame_last, want.frame_error),
						$sformatf("got dev %0d data %h ok %b last %b err %b",
							got.device_index, got.group_data, got.pec_ok,
							got.frame_last, got.frame_error)});
				end
			end
		end
	end

	initial begin : watchdog
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/dcp_pkg.sv
hdl/dcp_if.sv
hdl/daisy_chain_pec15_checker.sv
sim/daisy_chain_pec15_checker_tb.sv
